[rtl/tmcr_pkg.sv]
package tmcr_pkg;

    // Raster geometry defaults; the top level takes these as parameter defaults.
    localparam int DEF_COLUMNS     = 40;
    localparam int DEF_ROWS        = 25;
    localparam int DEF_VIDEO_DEPTH = 2048;

    // Fixed geometry of the glyphs and of the stream fields.
    localparam int GLYPH_LINES = 8;
    localparam int GLYPH_DEPTH = 2048;
    localparam int LINE_W      = 3;
    localparam int COL_W       = 6;
    localparam int ROW_W       = 5;
    localparam int BYTE_W      = 8;
    localparam int ADDR_IN_W   = 11;
    localparam int KIND_W      = 2;
    localparam int SCAN_W      = ROW_W + LINE_W;

    // Port widths.
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int SCROLL_W    = 16;

    // Item kinds carried in the slave-side tuser.
    typedef enum logic [KIND_W-1:0] {
        KIND_VIDEO_WR = 2'd0,
        KIND_GLYPH_WR = 2'd1,
        KIND_SLICE    = 2'd2
    } kind_t;

    // Register indexes, decoded from paddr[2].
    typedef enum logic {
        REG_BIT_ORDER = 1'b0,
        REG_SCROLL    = 1'b1
    } reg_idx_t;

    // Everything a slice carries alongside its pixels.
    typedef struct packed {
        logic [BYTE_W-1:0] cursor_count;
        logic              frame_parity;
        logic              frame_end;
        logic [SCAN_W-1:0] scan_line;
        logic [COL_W-1:0]  column;
    } slice_info_t;

endpackage

[rtl/tmcr_store.sv]
module tmcr_store #(
    parameter int DEPTH = tmcr_pkg::GLYPH_DEPTH,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [tmcr_pkg::BYTE_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic [tmcr_pkg::BYTE_W-1:0] rd_data
);
    import tmcr_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // A read and a write at the same edge return the old contents.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/tmcr_raster.sv]
module tmcr_raster #(
    parameter int COLUMNS     = tmcr_pkg::DEF_COLUMNS,
    parameter int ROWS        = tmcr_pkg::DEF_ROWS,
    parameter int VIDEO_DEPTH = tmcr_pkg::DEF_VIDEO_DEPTH,
    localparam int VADDR_W    = $clog2(VIDEO_DEPTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [VADDR_W-1:0]    scroll_mod,
    output logic [VADDR_W-1:0]    cell_addr,
    output tmcr_pkg::slice_info_t info
);
    import tmcr_pkg::*;

    localparam int OFF_W  = COL_W + ROW_W;
    localparam int CELL_W = VADDR_W + 2;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              parity_reg, parity_next;
    logic [BYTE_W-1:0] blink_reg, blink_next;

    logic              frame_start;
    logic              last_col;
    logic              last_line;
    logic              last_row;
    logic [OFF_W-1:0]  offset;
    logic [CELL_W-1:0] sum0;
    logic [CELL_W-1:0] sum1;
    logic [CELL_W-1:0] sum2;

    assign frame_start = (col_reg == '0) && (line_reg == '0) && (row_reg == '0);
    assign last_col    = (col_reg == COL_W'(COLUMNS - 1));
    assign last_line   = (line_reg == LINE_W'(GLYPH_LINES - 1));
    assign last_row    = (row_reg == ROW_W'(ROWS - 1));

    // The offset stays below 2048 and the reduced scroll below the depth, so the
    // sum is under three times the depth and two conditional subtracts wrap it.
    always_comb
    begin
        offset = OFF_W'(row_reg) * OFF_W'(COLUMNS) + OFF_W'(col_reg);
        sum0   = CELL_W'(scroll_mod) + CELL_W'(offset);
        sum1   = (sum0 >= CELL_W'(VIDEO_DEPTH)) ? sum0 - CELL_W'(VIDEO_DEPTH) : sum0;
        sum2   = (sum1 >= CELL_W'(VIDEO_DEPTH)) ? sum1 - CELL_W'(VIDEO_DEPTH) : sum1;
    end

    assign cell_addr = VADDR_W'(sum2);

    always_comb
    begin
        info.column       = col_reg;
        info.scan_line    = {row_reg, line_reg};
        info.frame_end    = last_col && last_line && last_row;
        info.frame_parity = parity_reg ^ frame_start;
        info.cursor_count = blink_reg + BYTE_W'(frame_start);
    end

    always_comb
    begin
        col_next    = col_reg;
        line_next   = line_reg;
        row_next    = row_reg;
        parity_next = parity_reg;
        blink_next  = blink_reg;
        if (step)
        begin
            parity_next = info.frame_parity;
            blink_next  = info.cursor_count;
            if (last_col)
            begin
                col_next = '0;
                if (last_line)
                begin
                    line_next = '0;
                    row_next  = last_row ? '0 : row_reg + 1'b1;
                end
                else
                begin
                    line_next = line_reg + 1'b1;
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            line_reg   <= '0;
            row_reg    <= '0;
            parity_reg <= 1'b0;
            blink_reg  <= '0;
        end
        else
        begin
            col_reg    <= col_next;
            line_reg   <= line_next;
            row_reg    <= row_next;
            parity_reg <= parity_next;
            blink_reg  <= blink_next;
        end
    end

endmodule

[rtl/text_mode_cell_rasterizer.sv]
// Text-mode cell rasterizer for a COLUMNS x ROWS screen of 8x8 one-bit glyphs.
// Each slave-side transaction writes one byte of the video store (tuser kind 0),
// writes one byte of the glyph store (kind 1), or asks for the next cell slice
// (kind 2); kind 3 is accepted and dropped. Only slices produce a master-side
// transaction, which carries the eight pixels of one glyph line with the
// leftmost pixel in bit 7, its column and screen line, the frame parity and
// the cursor blink count, with tlast set on the last slice of the frame.
// The block accepts one transaction per clock while s_axis_tready is high. The
// video store is read on the edge that accepts a slice, the glyph store as the
// slice moves from stage 1 to stage 2, and the output register loads as it
// moves from stage 2 to the output, where it raises m_axis_tvalid. Stalls on
// the master side fill the empty stages first, so up to three slices can be
// in flight before s_axis_tready drops. Neither store is cleared at reset;
// reading a cell or glyph that was never written gives undefined pixels.
// Configuration (bit_order at byte address 0, scroll_start at 4) may be
// written only while no slice is in flight.
module text_mode_cell_rasterizer #(
    parameter int COLUMNS     = tmcr_pkg::DEF_COLUMNS,
    parameter int ROWS        = tmcr_pkg::DEF_ROWS,
    parameter int VIDEO_DEPTH = tmcr_pkg::DEF_VIDEO_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Slave side.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [10:0] address, [18:11] data, [23:19] zero.
    input  logic [tmcr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [1:0] kind.
    input  logic [tmcr_pkg::KIND_W-1:0]        s_axis_tuser,
    // Master side.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [7:0] pixel_bits, [13:8] column, [21:14] scan_line, [22] frame_parity,
    // [30:23] cursor_count, [31] zero.
    output logic [tmcr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // frame_end.
    output logic                               m_axis_tlast,
    // Configuration port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tmcr_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [tmcr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tmcr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import tmcr_pkg::*;

    localparam int VADDR_W = $clog2(VIDEO_DEPTH);
    localparam int CELL_W  = VADDR_W + 2;
    localparam int RED_W   = SCROLL_W + 8;
    localparam int GADDR_W = $clog2(GLYPH_DEPTH);

    function automatic logic [BYTE_W-1:0] reverse_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++)
        begin
            r[i] = b[BYTE_W-1-i];
        end
        return r;
    endfunction

    // Configuration registers. The scroll start is also kept reduced modulo
    // the video depth, worked out once when it is written.
    logic                bit_order_reg, bit_order_next;
    logic [SCROLL_W-1:0] scroll_reg, scroll_next;
    logic [VADDR_W-1:0]  scroll_mod_reg, scroll_mod_next;
    logic                cfg_we;
    reg_idx_t            cfg_idx;
    logic [RED_W-1:0]    scroll_rem;

    // Input decode.
    kind_t               kind;
    logic [ADDR_IN_W-1:0] in_addr;
    logic [BYTE_W-1:0]   in_data;
    logic                in_fire;
    logic                vid_we;
    logic                gly_we;
    logic                slice_fire;
    logic [CELL_W-1:0]   vid_wa_ext;
    logic [VADDR_W-1:0]  vid_wa;

    // Pipeline.
    logic                s1_ready;
    logic                s2_ready;
    logic                out_ready;
    logic                s1_valid_reg, s1_valid_next;
    logic                s2_valid_reg, s2_valid_next;
    logic                out_valid_reg, out_valid_next;
    slice_info_t         s1_info_reg;
    slice_info_t         s2_info_reg;
    slice_info_t         out_info_reg;
    logic [BYTE_W-1:0]   pix_reg;

    slice_info_t         cur_info;
    logic [VADDR_W-1:0]  cell_addr;
    logic [BYTE_W-1:0]   code;
    logic [BYTE_W-1:0]   glyph_byte;
    logic [GADDR_W-1:0]  glyph_ra;

    // ---------------------------------------------------------------
    // Configuration port: always ready, writes land on the access phase.
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    // Six restoring subtract steps bring any 16-bit value below the depth,
    // since the depth is at least 1024 and the quotient is below 64.
    always_comb
    begin
        scroll_rem = RED_W'(pwdata[SCROLL_W-1:0]);
        for (int j = 5; j >= 0; j--)
        begin
            if (scroll_rem >= (RED_W'(VIDEO_DEPTH) << j))
            begin
                scroll_rem = scroll_rem - (RED_W'(VIDEO_DEPTH) << j);
            end
        end
    end

    always_comb
    begin
        bit_order_next  = bit_order_reg;
        scroll_next     = scroll_reg;
        scroll_mod_next = scroll_mod_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_BIT_ORDER:
                begin
                    bit_order_next = pwdata[0];
                end
                REG_SCROLL:
                begin
                    scroll_next     = pwdata[SCROLL_W-1:0];
                    scroll_mod_next = VADDR_W'(scroll_rem);
                end
                default:
                begin
                    bit_order_next = bit_order_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_BIT_ORDER: prdata = APB_DATA_W'(bit_order_reg);
            REG_SCROLL:    prdata = APB_DATA_W'(scroll_reg);
            default:       prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Input transactions. Every stage moves when the one after it can
    // take its contents, so bubbles close up under a master-side stall.
    // ---------------------------------------------------------------
    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign s2_ready      = !s2_valid_reg || out_ready;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign s_axis_tready = s1_ready;
    assign in_fire       = s_axis_tvalid && s1_ready;

    assign kind    = kind_t'(s_axis_tuser);
    assign in_addr = s_axis_tdata[ADDR_IN_W-1:0];
    assign in_data = s_axis_tdata[ADDR_IN_W +: BYTE_W];

    always_comb
    begin
        vid_we     = 1'b0;
        gly_we     = 1'b0;
        slice_fire = 1'b0;
        unique case (kind)
            KIND_VIDEO_WR: vid_we     = in_fire;
            KIND_GLYPH_WR: gly_we     = in_fire;
            KIND_SLICE:    slice_fire = in_fire;
            default:
            begin
                // Unused kind: accepted and dropped.
                slice_fire = 1'b0;
            end
        endcase
    end

    // A video write address wraps modulo the depth; it is below twice the
    // smallest depth, so one subtract is enough.
    always_comb
    begin
        vid_wa_ext = CELL_W'(in_addr);
        if (vid_wa_ext >= CELL_W'(VIDEO_DEPTH))
        begin
            vid_wa_ext = vid_wa_ext - CELL_W'(VIDEO_DEPTH);
        end
        vid_wa = VADDR_W'(vid_wa_ext);
    end

    // Raster counters and the cell address of the slice about to be taken.
    tmcr_raster #(
        .COLUMNS     (COLUMNS),
        .ROWS        (ROWS),
        .VIDEO_DEPTH (VIDEO_DEPTH)
    ) u_raster (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (slice_fire),
        .scroll_mod (scroll_mod_reg),
        .cell_addr  (cell_addr),
        .info       (cur_info)
    );

    // Stage 1: the character code is read on the edge that accepts the slice.
    tmcr_store #(
        .DEPTH (VIDEO_DEPTH)
    ) u_video_store (
        .clk     (clk),
        .wr_en   (vid_we),
        .wr_addr (vid_wa),
        .wr_data (in_data),
        .rd_en   (s1_ready),
        .rd_addr (cell_addr),
        .rd_data (code)
    );

    // Stage 2: the glyph line is read as the slice leaves stage 1. A glyph
    // write accepted on that same edge comes later in the stream, and the
    // store returns the old byte, which keeps the order.
    assign glyph_ra = {code, s1_info_reg.scan_line[LINE_W-1:0]};

    tmcr_store #(
        .DEPTH (GLYPH_DEPTH)
    ) u_glyph_store (
        .clk     (clk),
        .wr_en   (gly_we),
        .wr_addr (in_addr),
        .wr_data (in_data),
        .rd_en   (s2_ready),
        .rd_addr (glyph_ra),
        .rd_data (glyph_byte)
    );

    assign s1_valid_next  = s1_ready  ? slice_fire   : s1_valid_reg;
    assign s2_valid_next  = s2_ready  ? s1_valid_reg : s2_valid_reg;
    assign out_valid_next = out_ready ? s2_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            bit_order_reg  <= 1'b0;
            scroll_reg     <= '0;
            scroll_mod_reg <= '0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            s2_valid_reg   <= s2_valid_next;
            out_valid_reg  <= out_valid_next;
            bit_order_reg  <= bit_order_next;
            scroll_reg     <= scroll_next;
            scroll_mod_reg <= scroll_mod_next;
        end
    end

    // Slice payload follows its valid bit through the stages.
    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_info_reg <= cur_info;
        end
        if (s2_ready)
        begin
            s2_info_reg <= s1_info_reg;
        end
        if (out_ready)
        begin
            out_info_reg <= s2_info_reg;
            pix_reg      <= bit_order_reg ? reverse_byte(glyph_byte) : glyph_byte;
        end
    end

    // ---------------------------------------------------------------
    // Master side.
    // ---------------------------------------------------------------
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_info_reg.frame_end;
    assign m_axis_tdata  = {1'b0,
                            out_info_reg.cursor_count,
                            out_info_reg.frame_parity,
                            out_info_reg.scan_line,
                            out_info_reg.column,
                            pix_reg};

endmodule

[verif/text_mode_cell_rasterizer_tb.sv]
`timescale 1ns / 1ps

module text_mode_cell_rasterizer_tb;

    import tmcr_pkg::*;

    // Screen geometry of the instance under test (parameter defaults).
    localparam int COLUMNS     = DEF_COLUMNS;
    localparam int ROWS        = DEF_ROWS;
    localparam int VIDEO_DEPTH = DEF_VIDEO_DEPTH;

    // Kind code 3 is not a member of kind_t; the block must drop it silently.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // Cycles to let pass after the last slice before touching configuration.
    // It covers the pipeline stages, with margin for writes still in flight.
    localparam int SETTLE_CYCLES = 8;

    // Character codes used when video cells are filled ahead of the slices.
    // Their glyph lines are all written once the directed table has run.
    localparam int FILL_CODES = 16;

    // One cell slice as it should appear on the master side.
    typedef struct packed {
        logic [BYTE_W-1:0] pixels;
        logic [COL_W-1:0]  column;
        logic [SCAN_W-1:0] scan_line;
        logic              frame_end;
        logic              frame_parity;
        logic [BYTE_W-1:0] cursor_count;
    } slice_t;

    // A row of the directed table. Where has_want is set, the slice it causes
    // must match want exactly instead of what the raster predictor computes.
    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [ADDR_IN_W-1:0] addr;
        logic [BYTE_W-1:0]    data;
        logic                 has_want;
        slice_t               want;
    } stim_row_t;

    localparam slice_t NO_SLICE = '0;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // [10:0] address, [18:11] data, [23:19] zero.
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // [1:0] kind.
    logic [KIND_W-1:0]      s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [7:0] pixel_bits, [13:8] column, [21:14] scan_line, [22] frame_parity,
    // [30:23] cursor_count, [31] zero.
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // frame_end.
    logic                   m_axis_tlast;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    text_mode_cell_rasterizer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Raster predictor: a private copy of both stores, the raster counters,
    // the frame flags and the two configuration registers.
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0]   video_mem [VIDEO_DEPTH];
    logic [BYTE_W-1:0]   glyph_mem [GLYPH_DEPTH];
    // Written marks: pixels built from an entry never written are undefined
    // and are not compared.
    bit                  video_known [VIDEO_DEPTH];
    bit                  glyph_known [GLYPH_DEPTH];
    logic [COL_W-1:0]    col_cnt;
    logic [LINE_W-1:0]   line_cnt;
    logic [ROW_W-1:0]    row_cnt;
    logic                parity_flag;
    logic [BYTE_W-1:0]   blink_cnt;
    logic                cfg_bit_order;
    logic [SCROLL_W-1:0] cfg_scroll;

    // Slices predicted but not yet seen on the master side, oldest first,
    // with a flag per slice telling whether its pixels are defined.
    slice_t pending_slices [$];
    bit     pending_known [$];

    stim_row_t directed_rows [$];

    int mismatch_count = 0;

    // Gap limits for the sender and the receiver, changed from phase to phase.
    int tx_gap_max = 0;
    int rx_gap_max = 0;

    // Applies one accepted input item to the predicted state. Returns 1 when
    // the item is a slice request, with the slice it must produce in s and
    // known set when its pixels come from written entries only.
    function automatic bit raster_step(input logic [KIND_W-1:0] kind,
                                       input logic [ADDR_IN_W-1:0] addr,
                                       input logic [BYTE_W-1:0] data,
                                       output slice_t s,
                                       output bit known);
        int                  cell_idx;
        logic [BYTE_W-1:0]   code;
        logic [BYTE_W-1:0]   glyph;
        logic [BYTE_W-1:0]   shown;
        s     = NO_SLICE;
        known = 1'b0;
        case (kind)
            KIND_VIDEO_WR:
            begin
                video_mem[int'(addr) % VIDEO_DEPTH]   = data;
                video_known[int'(addr) % VIDEO_DEPTH] = 1'b1;
                return 1'b0;
            end
            KIND_GLYPH_WR:
            begin
                glyph_mem[addr]   = data;
                glyph_known[addr] = 1'b1;
                return 1'b0;
            end
            KIND_SLICE:
            begin
                // The first slice of a frame flips the parity and counts a frame.
                if (col_cnt == 0 && line_cnt == 0 && row_cnt == 0)
                begin
                    parity_flag = ~parity_flag;
                    blink_cnt   = blink_cnt + 1'b1;
                end
                cell_idx = (int'(cfg_scroll) + int'(row_cnt) * COLUMNS + int'(col_cnt))
                           % VIDEO_DEPTH;
                code  = video_mem[cell_idx];
                glyph = glyph_mem[{code, line_cnt}];
                known = video_known[cell_idx] ? glyph_known[{code, line_cnt}] : 1'b0;
                // With bit_order set, glyph bit 0 becomes the leftmost pixel.
                for (int i = 0; i < BYTE_W; i++)
                    shown[i] = cfg_bit_order ? glyph[BYTE_W-1-i] : glyph[i];
                s.pixels       = shown;
                s.column       = col_cnt;
                s.scan_line    = {row_cnt, line_cnt};
                s.frame_end    = (int'(col_cnt) == COLUMNS - 1) &&
                                 (int'(line_cnt) == GLYPH_LINES - 1) &&
                                 (int'(row_cnt) == ROWS - 1);
                s.frame_parity = parity_flag;
                s.cursor_count = blink_cnt;
                // Column first, then glyph line, then character row.
                if (int'(col_cnt) >= COLUMNS - 1)
                begin
                    col_cnt = '0;
                    if (int'(line_cnt) >= GLYPH_LINES - 1)
                    begin
                        line_cnt = '0;
                        if (int'(row_cnt) >= ROWS - 1)
                            row_cnt = '0;
                        else
                            row_cnt = row_cnt + 1'b1;
                    end
                    else
                    begin
                        line_cnt = line_cnt + 1'b1;
                    end
                end
                else
                begin
                    col_cnt = col_cnt + 1'b1;
                end
                return 1'b1;
            end
            default:
            begin
                return 1'b0;
            end
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h",
                 $time, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Slave side. Inputs move at the falling edge; a transaction is taken
    // at the rising edge where tvalid and tready are both high. tvalid stays
    // high between back-to-back items and drops only when a gap is drawn or a burst ends.
    // ------------------------------------------------------------------
    task automatic push_item(input logic [KIND_W-1:0] kind,
                             input logic [ADDR_IN_W-1:0] addr,
                             input logic [BYTE_W-1:0] data,
                             input bit has_want,
                             input slice_t want);
        int     gap;
        slice_t s;
        bit     known;
        gap = $urandom_range(0, tx_gap_max);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - ADDR_IN_W - BYTE_W){1'b0}}, data, addr};
        s_axis_tuser  <= kind;
        do @(posedge clk); while (!s_axis_tready);
        if (raster_step(kind, addr, data, s, known))
        begin
            pending_slices.push_back(has_want ? want : s);
            pending_known.push_back(has_want || known);
        end
    endtask

    task automatic end_burst();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // Random traffic: slice requests make up slice_pct percent, the rest are
    // store writes with a few items of the unused kind mixed in.
    task automatic random_items(input int count, input int slice_pct);
        logic [KIND_W-1:0] kind;
        int                pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < slice_pct)
                kind = KIND_SLICE;
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick < 5)
                    kind = KIND_VIDEO_WR;
                else if (pick < 9)
                    kind = KIND_GLYPH_WR;
                else
                    kind = KIND_UNUSED;
            end
            push_item(kind, ADDR_IN_W'($urandom_range(0, 2047)),
                      BYTE_W'($urandom_range(0, 255)), 1'b0, NO_SLICE);
        end
        end_burst();
    endtask

    // Writes a code with defined glyph lines into every video cell that the
    // next n slices will read, each cell once.
    task automatic prefill_cells(input int n);
        logic [COL_W-1:0]  c;
        logic [LINE_W-1:0] l;
        logic [ROW_W-1:0]  r;
        int                idx;
        bit                done [VIDEO_DEPTH];
        c = col_cnt;
        l = line_cnt;
        r = row_cnt;
        for (int k = 0; k < n; k++)
        begin
            idx = (int'(cfg_scroll) + int'(r) * COLUMNS + int'(c)) % VIDEO_DEPTH;
            if (!done[idx])
            begin
                done[idx] = 1'b1;
                push_item(KIND_VIDEO_WR, ADDR_IN_W'(idx),
                          BYTE_W'($urandom_range(0, FILL_CODES - 1)), 1'b0, NO_SLICE);
            end
            if (int'(c) >= COLUMNS - 1)
            begin
                c = '0;
                if (int'(l) >= GLYPH_LINES - 1)
                begin
                    l = '0;
                    if (int'(r) >= ROWS - 1)
                        r = '0;
                    else
                        r = r + 1'b1;
                end
                else
                begin
                    l = l + 1'b1;
                end
            end
            else
            begin
                c = c + 1'b1;
            end
        end
        end_burst();
    endtask

    // Waits until every predicted slice has come out, then lets the pipeline
    // settle so that a store write accepted last has surely landed.
    task automatic drain();
        while (pending_slices.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Configuration port: an APB write followed by a read back of the same
    // register. Only called while the raster pipeline is empty.
    // ------------------------------------------------------------------
    task automatic program_register(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] want;
        logic [APB_DATA_W-1:0] got;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == REG_BIT_ORDER)
        begin
            cfg_bit_order = value[0];
            want          = {31'b0, value[0]};
        end
        else
        begin
            cfg_scroll = value[SCROLL_W-1:0];
            want       = {16'b0, value[SCROLL_W-1:0]};
        end
        // Back-to-back read of the same register.
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
            flag_mismatch(idx == REG_BIT_ORDER ? "bit_order readback" : "scroll_start readback",
                          int'(got), int'(want));
    endtask

    task automatic run_phase(input logic order, input logic [SCROLL_W-1:0] scroll,
                             input int count, input int slice_pct,
                             input int tx_max, input int rx_max);
        drain();
        program_register(REG_BIT_ORDER, {31'b0, order});
        program_register(REG_SCROLL, {16'b0, scroll});
        tx_gap_max = tx_max;
        rx_gap_max = rx_max;
        prefill_cells(count);
        random_items(count, slice_pct);
    endtask

    // ------------------------------------------------------------------
    // Master side: draws a stall before each slice, then takes the slice and
    // compares it field by field with the oldest prediction.
    // ------------------------------------------------------------------
    initial
    begin
        int     gap;
        slice_t want;
        bit     pix_known;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = $urandom_range(0, rx_gap_max);
            @(negedge clk);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            if (pending_slices.size() == 0)
            begin
                flag_mismatch("unexpected slice", int'(m_axis_tdata), 0);
            end
            else
            begin
                want      = pending_slices.pop_front();
                pix_known = pending_known.pop_front();
                if (pix_known && m_axis_tdata[7:0] !== want.pixels)
                    flag_mismatch("pixel_bits", int'(m_axis_tdata[7:0]), int'(want.pixels));
                if (m_axis_tdata[13:8] !== want.column)
                    flag_mismatch("column", int'(m_axis_tdata[13:8]), int'(want.column));
                if (m_axis_tdata[21:14] !== want.scan_line)
                    flag_mismatch("scan_line", int'(m_axis_tdata[21:14]),
                                  int'(want.scan_line));
                if (m_axis_tlast !== want.frame_end)
                    flag_mismatch("frame_end", int'(m_axis_tlast), int'(want.frame_end));
                if (m_axis_tdata[22] !== want.frame_parity)
                    flag_mismatch("frame_parity", int'(m_axis_tdata[22]),
                                  int'(want.frame_parity));
                if (m_axis_tdata[30:23] !== want.cursor_count)
                    flag_mismatch("cursor_count", int'(m_axis_tdata[30:23]),
                                  int'(want.cursor_count));
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        col_cnt       = '0;
        line_cnt      = '0;
        row_cnt       = '0;
        parity_flag   = 1'b0;
        blink_cnt     = '0;
        cfg_bit_order = 1'b0;
        cfg_scroll    = '0;

        // Directed table, run straight after reset with bit_order 0 and no
        // scroll. Each slice only reads cells and glyph lines written just
        // before it, since neither store holds anything defined at reset.
        // The first slice opens a frame, so parity and blink count read 1.
        directed_rows.push_back('{KIND_VIDEO_WR, 11'h000, 8'hFF, 1'b0, NO_SLICE});
        directed_rows.push_back('{KIND_GLYPH_WR, 11'h7F8, 8'h80, 1'b0, NO_SLICE});
        directed_rows.push_back('{KIND_SLICE, 11'h000, 8'h00, 1'b1,
                                  '{8'h80, 6'd0, 8'd0, 1'b0, 1'b1, 8'd1}});
        // Unused kind with every field bit set: dropped, no slice.
        directed_rows.push_back('{KIND_UNUSED, 11'h7FF, 8'hFF, 1'b0, NO_SLICE});
        directed_rows.push_back('{KIND_VIDEO_WR, 11'h001, 8'h00, 1'b0, NO_SLICE});
        directed_rows.push_back('{KIND_GLYPH_WR, 11'h000, 8'h01, 1'b0, NO_SLICE});
        directed_rows.push_back('{KIND_SLICE, 11'h7FF, 8'hFF, 1'b1,
                                  '{8'h01, 6'd1, 8'd0, 1'b0, 1'b1, 8'd1}});
        // Top addresses of both stores.
        directed_rows.push_back('{KIND_VIDEO_WR, 11'h7FF, 8'hAA, 1'b0, NO_SLICE});
        directed_rows.push_back('{KIND_GLYPH_WR, 11'h7FF, 8'h55, 1'b0, NO_SLICE});
        directed_rows.push_back('{KIND_VIDEO_WR, 11'h002, 8'h7F, 1'b0, NO_SLICE});
        directed_rows.push_back('{KIND_GLYPH_WR, 11'h3F8, 8'hFF, 1'b0, NO_SLICE});
        directed_rows.push_back('{KIND_SLICE, 11'h000, 8'h00, 1'b1,
                                  '{8'hFF, 6'd2, 8'd0, 1'b0, 1'b1, 8'd1}});
        // Overwriting a glyph line must show at once.
        directed_rows.push_back('{KIND_VIDEO_WR, 11'h003, 8'h00, 1'b0, NO_SLICE});
        directed_rows.push_back('{KIND_GLYPH_WR, 11'h000, 8'h00, 1'b0, NO_SLICE});
        directed_rows.push_back('{KIND_SLICE, 11'h000, 8'h00, 1'b1,
                                  '{8'h00, 6'd3, 8'd0, 1'b0, 1'b1, 8'd1}});
        directed_rows.push_back('{KIND_UNUSED, 11'h000, 8'h00, 1'b0, NO_SLICE});

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        tx_gap_max = 3;
        rx_gap_max = 3;
        foreach (directed_rows[i])
            push_item(directed_rows[i].kind, directed_rows[i].addr, directed_rows[i].data,
                      directed_rows[i].has_want, directed_rows[i].want);
        end_burst();

        // Write every glyph line of the codes used to fill video cells, back
        // to back, so that slices over filled cells show defined pixels.
        tx_gap_max = 0;
        for (int a = 0; a < FILL_CODES * GLYPH_LINES; a++)
            push_item(KIND_GLYPH_WR, ADDR_IN_W'(a), BYTE_W'($urandom_range(0, 255)),
                      1'b0, NO_SLICE);
        end_burst();

        // Random phases over several settings. Mirrored pixels with the
        // largest scroll offset, which wraps around the video store.
        run_phase(1'b1, 16'hFFFF, 120, 60, 16, 16);
        // No idling at all: writes land right behind slices in the pipeline.
        run_phase(1'b0, 16'h0000, 120, 60, 0, 0);
        // Mostly slices with little idling, crossing glyph lines.
        run_phase(1'b1, 16'd2047, 120, 95, 0, 3);
        run_phase(1'b0, 16'd2048, 120, 60, 16, 16);
        run_phase(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)), 120, 60, 3, 16);

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial
    begin
        #50_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/tmcr_pkg.sv
rtl/tmcr_store.sv
rtl/tmcr_raster.sv
rtl/text_mode_cell_rasterizer.sv
verif/text_mode_cell_rasterizer_tb.sv
